// ----- design/a2i_pkg.sv -----
// ----------------------------------------------------------------------------
// a2i_pkg
// Shared types, constants and helper functions for the ASCII to int64 parser.
// ----------------------------------------------------------------------------
package a2i_pkg;

  localparam int CHAR_W   = 8;
  localparam int RADIX_W  = 6;
  localparam int VALUE_W  = 64;
  localparam int CONS_W   = 13;
  localparam int STATUS_W = 2;
  localparam int DIGIT_W  = 6;
  // accumulator times base plus digit never exceeds 2^63 * 36 + 35
  localparam int PROD_W   = VALUE_W + RADIX_W;
  localparam int Q_DEPTH  = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  // Digit value given to anything that is no digit of any base
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;
  localparam logic [DIGIT_W-1:0] DIGIT_ALPHA = 6'd10;

  // Bases
  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NODIGITS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADBASE  = 2'd3;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // Classified character as it travels from front to back
  typedef struct packed {
    logic               last;
    logic               nul;
    logic               ws;
    logic               plus;
    logic               minus;
    logic               xmark;
    logic [DIGIT_W-1:0] digit;
  } token_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      d = DIGIT_W'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIGIT_W'(c - CH_UA) + DIGIT_ALPHA;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIGIT_W'(c - CH_LA) + DIGIT_ALPHA;
    end
    return d;
  endfunction

  function automatic logic base_invalid(input logic [RADIX_W-1:0] b);
    return (b == BASE_ONE) || (b > BASE_MAX);
  endfunction

endpackage

// ----- design/a2i_char_if.sv -----
// ----------------------------------------------------------------------------
// a2i_char_if
// Character stream channel: one character and an end-of-string flag.
// ----------------------------------------------------------------------------
interface a2i_char_if;
  logic                        valid;
  logic                        ready;
  logic [a2i_pkg::CHAR_W-1:0]  char_code;
  logic                        is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ----- design/a2i_result_if.sv -----
// ----------------------------------------------------------------------------
// a2i_result_if
// Result channel: parsed value, consumed character count and status.
// ----------------------------------------------------------------------------
interface a2i_result_if;
  logic                          valid;
  logic                          ready;
  logic [a2i_pkg::VALUE_W-1:0]   value;
  logic [a2i_pkg::CONS_W-1:0]    consumed;
  logic [a2i_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output value, output consumed, output status,
                  input ready);
  modport sink   (input valid, input value, input consumed, input status,
                  output ready);
endinterface

// ----- design/ascii_to_int64_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_to_int64_parser
// Parses a character stream into a saturating signed 64-bit integer.
// ----------------------------------------------------------------------------
// Throughput: one character per clock cycle while results are taken; set by the
//   single multiply-add and range compare of the parse engine.
// Result path: the last character of a string passes the token queue, then the
//   parse engine, which writes the result into its output register.
// Reset: clears radix to auto-detect, empties the queue and the output
//   register and returns the parser to whitespace skipping.
// ----------------------------------------------------------------------------
module ascii_to_int64_parser #(
  parameter int MAX_LEN = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [a2i_pkg::RADIX_W-1:0]   cfg_wdata,
  a2i_char_if.sink                      char_in,
  a2i_result_if.source                  result_out
);

  logic [a2i_pkg::RADIX_W-1:0] radix;
  logic                        push_valid;
  logic                        push_ready;
  a2i_pkg::token_t             push_token;
  logic                        pop_valid;
  logic                        pop_ready;
  a2i_pkg::token_t             pop_token;

  // Hold the radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= a2i_pkg::BASE_AUTO;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  a2i_front u_front (
    .char_in    (char_in),
    .push_valid (push_valid),
    .push_token (push_token),
    .push_ready (push_ready)
  );

  a2i_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_token (push_token),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_token  (pop_token),
    .pop_ready  (pop_ready)
  );

  a2i_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .radix      (radix),
    .pop_valid  (pop_valid),
    .pop_token  (pop_token),
    .pop_ready  (pop_ready),
    .result_out (result_out)
  );

endmodule

// ----- design/a2i_front.sv -----
// ----------------------------------------------------------------------------
// a2i_front
// Accepts characters and classifies them into tokens for the parse engine.
// ----------------------------------------------------------------------------
module a2i_front (
  a2i_char_if.sink          char_in,
  output logic              push_valid,
  output a2i_pkg::token_t   push_token,
  input  logic              push_ready
);

  // Pass the handshake straight to the queue
  assign push_valid     = char_in.valid;
  assign char_in.ready  = push_ready;

  // Classify the character
  always_comb begin
    push_token.last  = char_in.is_last;
    push_token.nul   = (char_in.char_code == a2i_pkg::CH_NUL);
    push_token.ws    = (char_in.char_code == a2i_pkg::CH_SPACE) ||
                       (char_in.char_code >= a2i_pkg::CH_TAB &&
                        char_in.char_code <= a2i_pkg::CH_CR);
    push_token.plus  = (char_in.char_code == a2i_pkg::CH_PLUS);
    push_token.minus = (char_in.char_code == a2i_pkg::CH_MINUS);
    push_token.xmark = (char_in.char_code == a2i_pkg::CH_LX) ||
                       (char_in.char_code == a2i_pkg::CH_UX);
    push_token.digit = a2i_pkg::digit_of(char_in.char_code);
  end

endmodule

// ----- design/a2i_queue.sv -----
// ----------------------------------------------------------------------------
// a2i_queue
// Short token queue that decouples the classifier from the parse engine.
// ----------------------------------------------------------------------------
module a2i_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  a2i_pkg::token_t   push_token,
  output logic              push_ready,
  output logic              pop_valid,
  output a2i_pkg::token_t   pop_token,
  input  logic              pop_ready
);

  localparam int DEPTH = a2i_pkg::Q_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  a2i_pkg::token_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_token  = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store tokens
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

endmodule

// ----- design/a2i_back.sv -----
// ----------------------------------------------------------------------------
// a2i_back
// Parse engine: runs the sign, prefix and digit state machine one token per cycle,
// stalling a closing token on an occupied output register that holds each finished result.
// ----------------------------------------------------------------------------
module a2i_back #(
  parameter int MAX_LEN = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [a2i_pkg::RADIX_W-1:0]    radix,
  input  logic                           pop_valid,
  input  a2i_pkg::token_t                pop_token,
  output logic                           pop_ready,
  a2i_result_if.source                   result_out
);

  localparam int POS_W  = $clog2(MAX_LEN + 1);
  localparam int VW     = a2i_pkg::VALUE_W;
  localparam int RW     = a2i_pkg::RADIX_W;
  localparam int PW     = a2i_pkg::PROD_W;

  a2i_pkg::phase_t  phase, phase_next;
  logic             negative, negative_next;
  logic [RW-1:0]    active_base, active_base_next;
  logic [VW-1:0]    accumulator, accumulator_next;
  logic             overflowed, overflowed_next;
  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] end_position, end_position_next;

  logic [VW-1:0]                   value_next;
  logic [a2i_pkg::CONS_W-1:0]      consumed_next;
  logic [a2i_pkg::STATUS_W-1:0]    status_next;
  logic                            out_free;
  logic                            take;

  // Hold a closing token while the output register is still occupied
  assign out_free  = !result_out.valid || result_out.ready;
  assign pop_ready = !pop_token.last || out_free;
  assign take      = pop_valid && pop_ready;

  // Step the parser on one token
  always_comb begin
    logic          cont;
    logic [PW-1:0] prod;
    logic [PW-1:0] limit;

    phase_next        = phase;
    negative_next     = negative;
    active_base_next  = active_base;
    accumulator_next  = accumulator;
    overflowed_next   = overflowed;
    position_next     = position;
    end_position_next = end_position;
    cont              = 1'b1;
    prod              = '0;
    limit             = '0;

    if (position < POS_W'(MAX_LEN)) begin
      // sample the base at the first character of a string
      if (position == '0) begin
        active_base_next = radix;
        if (a2i_pkg::base_invalid(radix)) begin
          phase_next = a2i_pkg::PH_DONE;
        end
      end

      if (phase_next == a2i_pkg::PH_DONE) begin
        cont = 1'b0;
      end else if (pop_token.nul) begin
        phase_next = a2i_pkg::PH_DONE;
        cont       = 1'b0;
      end

      // leading whitespace and sign
      if (cont && phase_next == a2i_pkg::PH_WS) begin
        if (pop_token.ws) begin
          cont = 1'b0;
        end else begin
          phase_next = a2i_pkg::PH_SIGN;
          if (pop_token.plus) begin
            cont = 1'b0;
          end else if (pop_token.minus) begin
            negative_next = 1'b1;
            cont          = 1'b0;
          end
        end
      end

      // base detection and hex prefix
      if (cont) begin
        if (phase_next == a2i_pkg::PH_SIGN) begin
          if (active_base_next == a2i_pkg::BASE_AUTO) begin
            if (pop_token.digit == '0) begin
              active_base_next  = a2i_pkg::BASE_OCT;
              end_position_next = position + 1'b1;
              phase_next        = a2i_pkg::PH_ZERO;
              cont              = 1'b0;
            end else begin
              active_base_next = a2i_pkg::BASE_DEC;
            end
          end
          if (cont) begin
            phase_next = a2i_pkg::PH_DIGITS;
          end
        end else if (phase_next == a2i_pkg::PH_ZERO) begin
          phase_next = a2i_pkg::PH_DIGITS;
          if (pop_token.xmark) begin
            active_base_next = a2i_pkg::BASE_HEX;
            cont             = 1'b0;
          end
        end
      end

      // digit accumulation with exact range test
      if (cont) begin
        if (pop_token.digit >= active_base_next) begin
          phase_next = a2i_pkg::PH_DONE;
        end else begin
          if (!overflowed) begin
            prod  = PW'(accumulator) * PW'(active_base_next) + PW'(pop_token.digit);
            limit = (PW'(1) << (VW - 1)) - PW'(!negative_next);
            if (prod > limit) begin
              overflowed_next = 1'b1;
            end else begin
              accumulator_next = prod[VW-1:0];
            end
          end
          end_position_next = position + 1'b1;
        end
      end

      position_next = position + 1'b1;
    end

    // Form the result
    if (a2i_pkg::base_invalid(active_base_next)) begin
      value_next    = '0;
      consumed_next = '0;
      status_next   = a2i_pkg::ST_BADBASE;
    end else if (end_position_next == '0) begin
      value_next    = '0;
      consumed_next = '0;
      status_next   = a2i_pkg::ST_NODIGITS;
    end else if (overflowed_next) begin
      value_next    = (VW'(1) << (VW - 1)) - VW'(!negative_next);
      consumed_next = a2i_pkg::CONS_W'(end_position_next);
      status_next   = a2i_pkg::ST_RANGE;
    end else begin
      value_next    = negative_next ? (VW'(0) - accumulator_next) : accumulator_next;
      consumed_next = a2i_pkg::CONS_W'(end_position_next);
      status_next   = a2i_pkg::ST_OK;
    end
  end

  // Advance parse state; clear it once a string closes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= a2i_pkg::PH_WS;
      negative     <= 1'b0;
      active_base  <= '0;
      accumulator  <= '0;
      overflowed   <= 1'b0;
      position     <= '0;
      end_position <= '0;
    end else if (take) begin
      if (pop_token.last) begin
        phase        <= a2i_pkg::PH_WS;
        negative     <= 1'b0;
        active_base  <= '0;
        accumulator  <= '0;
        overflowed   <= 1'b0;
        position     <= '0;
        end_position <= '0;
      end else begin
        phase        <= phase_next;
        negative     <= negative_next;
        active_base  <= active_base_next;
        accumulator  <= accumulator_next;
        overflowed   <= overflowed_next;
        position     <= position_next;
        end_position <= end_position_next;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        result_out.valid <= 1'b0;
      end
      if (take && pop_token.last) begin
        result_out.valid <= 1'b1;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (take && pop_token.last) begin
      result_out.value    <= value_next;
      result_out.consumed <= consumed_next;
      result_out.status   <= status_next;
    end
  end

endmodule
